/* rtl/core/uttr_pkg.sv */
// Package for the UART ring buffer unit: depths, index widths, codes and stage types.
package uttr_pkg;

   localparam int TX_DEPTH = 1024;
   localparam int RX_DEPTH = 1024;

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);

   localparam int BYTE_W = 8;
   localparam int FILL_W = 11;

   typedef enum logic [1:0] {
      ACT_PUT  = 2'd0,
      ACT_GET  = 2'd1,
      ACT_DONE = 2'd2,
      ACT_RECV = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TX_FULL   = 3'd1,
      ST_RX_EMPTY  = 3'd2,
      ST_RX_DROP   = 3'd3,
      ST_NO_SEND   = 3'd4
   } status_type;

   // Everything about a result except the byte, which arrives from a store's
   // registered read port that loads when the item is accepted.
   typedef struct packed {
      status_type          status;
      logic                send_valid;
      logic                kick_tx;
      logic [FILL_W-1:0]   rx_fill;
      logic                from_rx;
      logic                from_tx;
   } pend_type;

endpackage

/* rtl/core/uttr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered, enabled read.
module uttr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/uart_tx_rx_ring_buffers_unit.sv */
// Top level of the UART transmit and receive ring buffer unit.
//
// Each input item carries an action (put a transmit byte, get a received
// byte, transmitter done, byte received) and a data byte. Every item gives
// exactly one result item: a status code, a data byte, a send flag, a
// transmit kick and the receive fill after the item.
// An item is taken in at a clock edge with req_valid high and req_stall low;
// its result passes the pending stage and output register to the rsp_ channel.
// One item can be accepted every cycle while req_stall is low. The pointers and
// fill count update at acceptance; the byte comes from the store's registered
// read port in the next cycle and joins the rest of the result in the output
// register. When the receiver holds rsp_stall, the output register keeps its
// item, one more item waits in the pending stage, and then req_stall rises so
// that no further item is taken until the output drains.
// Synchronous reset empties both queues, marks the transmitter idle and
// drops any result in flight. The byte stores need no clearing: no entry is
// read before it was written.
module uart_tx_rx_ring_buffers_unit
   import uttr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [BYTE_W-1:0]   req_data_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_send_valid,
   output logic                rsp_kick_tx,
   output logic [FILL_W-1:0]   rsp_rx_fill
);

   logic [TX_AW-1:0] tx_rd_ff, tx_rd_in, tx_wr_ff, tx_wr_in;
   logic [RX_AW-1:0] rx_rd_ff, rx_rd_in, rx_wr_ff, rx_wr_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic             tx_idle_ff, tx_idle_in;

   logic             pend_valid_ff, pend_valid_in;
   pend_type         pend_ff, pend_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_send_ff, rsp_kick_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   logic             accept, out_free, pend_move;
   logic             tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
   logic [TX_AW-1:0] tx_wr_next, tx_rd_next;
   logic [RX_AW-1:0] rx_wr_next, rx_rd_next;
   logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;
   action_type       action;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_move = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign action    = action_type'(req_action);

   assign tx_wr_next = (tx_wr_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd_next = (tx_rd_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_ff + 1'b1;
   assign rx_wr_next = (rx_wr_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_next = (rx_rd_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_ff + 1'b1;

   always_comb begin
      tx_rd_in    = tx_rd_ff;
      tx_wr_in    = tx_wr_ff;
      rx_rd_in    = rx_rd_ff;
      rx_wr_in    = rx_wr_ff;
      rx_count_in = rx_count_ff;
      tx_idle_in  = tx_idle_ff;
      tx_wr_en    = 1'b0;
      tx_rd_en    = 1'b0;
      rx_wr_en    = 1'b0;
      rx_rd_en    = 1'b0;
      pend_in            = '0;
      pend_in.status     = ST_OK;

      if (accept) begin
         case (action)
            ACT_PUT: begin
               // The transmit queue keeps one slot free to tell full from empty.
               if (tx_wr_next == tx_rd_ff) begin
                  pend_in.status = ST_TX_FULL;
               end else begin
                  tx_wr_en        = 1'b1;
                  tx_wr_in        = tx_wr_next;
                  pend_in.kick_tx = tx_idle_ff;
               end
            end
            ACT_GET: begin
               if (rx_count_ff == '0) begin
                  pend_in.status = ST_RX_EMPTY;
               end else begin
                  rx_rd_en        = 1'b1;
                  rx_rd_in        = rx_rd_next;
                  rx_count_in     = rx_count_ff - 1'b1;
                  pend_in.from_rx = 1'b1;
               end
            end
            ACT_DONE: begin
               if (tx_rd_ff != tx_wr_ff) begin
                  tx_rd_en           = 1'b1;
                  tx_rd_in           = tx_rd_next;
                  tx_idle_in         = 1'b0;
                  pend_in.send_valid = 1'b1;
                  pend_in.from_tx    = 1'b1;
               end else begin
                  tx_idle_in     = 1'b1;
                  pend_in.status = ST_NO_SEND;
               end
            end
            ACT_RECV: begin
               if (rx_count_ff == RX_CW'(RX_DEPTH)) begin
                  pend_in.status = ST_RX_DROP;
               end else begin
                  rx_wr_en    = 1'b1;
                  rx_wr_in    = rx_wr_next;
                  rx_count_in = rx_count_ff + 1'b1;
               end
            end
            default: begin
               pend_in.status = ST_OK;
            end
         endcase
      end
      pend_in.rx_fill = FILL_W'(rx_count_in);
   end

   assign pend_valid_in = accept || (pend_valid_ff && !pend_move);
   assign rsp_valid_in  = pend_move || (rsp_valid_ff && rsp_stall);

   always_comb begin
      if (pend_ff.from_rx) begin
         rsp_data_in = rx_rd_data;
      end else if (pend_ff.from_tx) begin
         rsp_data_in = tx_rd_data;
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_rd_ff      <= '0;
         tx_wr_ff      <= '0;
         rx_rd_ff      <= '0;
         rx_wr_ff      <= '0;
         rx_count_ff   <= '0;
         tx_idle_ff    <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tx_rd_ff      <= tx_rd_in;
         tx_wr_ff      <= tx_wr_in;
         rx_rd_ff      <= rx_rd_in;
         rx_wr_ff      <= rx_wr_in;
         rx_count_ff   <= rx_count_in;
         tx_idle_ff    <= tx_idle_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_status_ff <= pend_ff.status;
         rsp_data_ff   <= rsp_data_in;
         rsp_send_ff   <= pend_ff.send_valid;
         rsp_kick_ff   <= pend_ff.kick_tx;
         rsp_fill_ff   <= pend_ff.rx_fill;
      end
   end

   // The read ports load only when an item is accepted, so a byte waiting in
   // the pending stage stays on rd_data until it moves on.
   uttr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TX_DEPTH)
   ) u_tx_store (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_ff),
      .wr_data (req_data_in),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_ff),
      .rd_data (tx_rd_data)
   );

   uttr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RX_DEPTH)
   ) u_rx_store (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_ff),
      .wr_data (req_data_in),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_ff),
      .rd_data (rx_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_send_valid = rsp_send_ff;
   assign rsp_kick_tx    = rsp_kick_ff;
   assign rsp_rx_fill    = rsp_fill_ff;

endmodule
